// File: rtl/isp_pkg.sv
// ----------------------------------------------------------------------------
// isp_pkg
// Shared types and constants for the insertion sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package isp_pkg;

	localparam int CAPACITY_DEF = 32;

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] sorted_value;
		logic               last_out;
		logic               overflow;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic insert;
		logic pop;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic one_left;
	} dp_status_t;

endpackage

`default_nettype wire

// File: rtl/isp_ctrl.sv
// ----------------------------------------------------------------------------
// isp_ctrl
// Batch controller: fill phase accepts values, drain phase emits the batch.
// ----------------------------------------------------------------------------
`default_nettype none

module isp_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_last,
	output logic                    in_stall,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output isp_pkg::dp_cmd_t        cmd,
	input  wire isp_pkg::dp_status_t status
);
	import isp_pkg::*;

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} state_t;

	state_t state_q;
	logic   in_stall_q;
	logic   out_valid_q;

	assign in_stall   = in_stall_q;
	assign out_valid  = out_valid_q;
	assign cmd.insert = in_valid & ~in_stall_q;
	assign cmd.pop    = out_valid_q & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			in_stall_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_FILL: begin
					if (cmd.insert && in_last) begin
						state_q     <= ST_DRAIN;
						in_stall_q  <= 1'b1;
						out_valid_q <= 1'b1;
					end
				end
				ST_DRAIN: begin
					if (cmd.pop && status.one_left) begin
						state_q     <= ST_FILL;
						in_stall_q  <= 1'b0;
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q     <= ST_FILL;
					in_stall_q  <= 1'b0;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/isp_datapath.sv
// ----------------------------------------------------------------------------
// isp_datapath
// Row of sorting cells: parallel compare-and-shift insert, shift-out drain.
// ----------------------------------------------------------------------------
`default_nettype none

module isp_datapath #(
	parameter int CAPACITY = isp_pkg::CAPACITY_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic                cfg_wr_data,
	input  wire isp_pkg::dp_cmd_t    cmd,
	input  wire logic signed [31:0]  value,
	output isp_pkg::dp_status_t      status,
	output isp_pkg::out_item_t       out_item
);
	import isp_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic signed [31:0] store_q [CAPACITY];
	logic [CW-1:0]      fill_q;
	logic               ovf_q;
	logic               descending_q;

	logic [CAPACITY-1:0] valid;
	logic [CAPACITY-1:0] pass;     // entry empty or new value moves past it
	logic [CAPACITY-1:0] shift;    // entry moves up one cell
	logic [CAPACITY-1:0] take_v;   // cell receives the new value
	logic                full;

	assign full = (fill_q == CW'(CAPACITY));

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			valid[i] = (CW'(i) < fill_q);
			pass[i]  = ~valid[i] | (descending_q ? (value > store_q[i]) : (value < store_q[i]));
		end
		// the insert scan stops at the first entry (from cell 0) the value does not pass
		for (int i = 0; i < CAPACITY; i++) begin
			shift[i] = valid[i] & (&(pass | ~({CAPACITY{1'b1}} << i)));
		end
		take_v[0] = shift[0] | ~valid[0];
		for (int i = 1; i < CAPACITY; i++) begin
			take_v[i] = valid[i-1] & ~shift[i-1] & (shift[i] | ~valid[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (cmd.pop) begin
				if (i < CAPACITY - 1) begin
					store_q[i] <= store_q[(i < CAPACITY - 1) ? i + 1 : i];
				end
			end else if (cmd.insert && !full) begin
				if (i > 0 && shift[(i > 0) ? i - 1 : 0]) begin
					store_q[i] <= store_q[(i > 0) ? i - 1 : 0];
				end else if (take_v[i]) begin
					store_q[i] <= value;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			ovf_q        <= 1'b0;
			descending_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				descending_q <= cfg_wr_data;
			end
			if (cmd.insert) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					fill_q <= fill_q + CW'(1);
				end
			end else if (cmd.pop) begin
				fill_q <= fill_q - CW'(1);
				if (status.one_left) begin
					ovf_q <= 1'b0;
				end
			end
		end
	end

	assign status.one_left       = (fill_q == CW'(1));
	assign out_item.sorted_value = store_q[0];
	assign out_item.last_out     = status.one_left;
	assign out_item.overflow     = ovf_q;

endmodule

`default_nettype wire

// File: rtl/insertion_sorter.sv
// ----------------------------------------------------------------------------
// insertion_sorter
// Stable batch sorter for signed 32-bit values, ascending or descending.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  in       | input     | in_valid / in_stall | in_data (value, last)
//  out      | output    | out_valid/out_stall | out_data (sorted_value, last_out, overflow)
//  cfg      | input     | cfg_wr_en           | cfg_wr_data (descending)
//
// One value is inserted per cycle while filling; all cells compare at once.
// After a last transaction the batch drains one result per cycle from cell 0
// while the output is not stalled, one result per stored value (at most
// CAPACITY; dropped values produce no result).
// Input is stalled during the drain; an output stall holds the drain.
// Reset clears fill count, overflow flag and order; cell contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module insertion_sorter #(
	parameter int CAPACITY = isp_pkg::CAPACITY_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire isp_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output isp_pkg::out_item_t      out_data,
	input  wire logic               cfg_wr_en,
	input  wire logic               cfg_wr_data
);
	import isp_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	isp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_last   (in_data.last),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	isp_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.value       (in_data.value),
		.status      (status),
		.out_item    (out_data)
	);

endmodule

`default_nettype wire

// File: rtl/isp_checker.sv
// ----------------------------------------------------------------------------
// isp_checker
// Port-level checks on batch sequencing of the insertion sorter.
// ----------------------------------------------------------------------------
`default_nettype none

module isp_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire isp_pkg::in_item_t  in_data,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire isp_pkg::out_item_t out_data
);
	import isp_pkg::*;

	// no input taken while a batch drains
	a_stall_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input not stalled during drain");

	// a last transaction starts the drain
	a_last_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_data.last) |=> out_valid)
		else $error("no output after last input");

	// drain ends right after the final result
	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && out_data.last_out) |=> !out_valid)
		else $error("output continues after final result");

	// a value without last produces nothing
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid && !(in_valid && !in_stall && in_data.last)) |=> !out_valid)
		else $error("output without a last input");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(out_data))
		else $error("stalled result changed");

endmodule

bind insertion_sorter isp_checker u_isp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
